/* design/assert_macros.svh */
// Assertion macros used by the port-level checker of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/hodr_pkg.sv */
// Package for the hour offset date rollover unit: field widths, offset limits
// and the month length lookup. No dependencies.
package hodr_pkg;

   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 16;
   localparam int OFS_W   = 5;

   localparam logic signed [OFS_W-1:0] OFFSET_RESET = -5'sd3;
   localparam logic signed [OFS_W-1:0] OFFSET_MIN   = -5'sd12;
   localparam logic signed [OFS_W-1:0] OFFSET_MAX   = 5'sd14;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] FEB_LEAP_DAYS    = 5'd29;
   localparam logic [DAY_W-1:0] ODD_MONTH_DAYS   = 5'd30;

   typedef logic [DAY_W-1:0] month_len_type [0:12];
   localparam month_len_type MONTH_LEN = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Days in a month; months outside January..December count as 30 days.
   function automatic logic [DAY_W-1:0] days_of(input logic [MONTH_W-1:0] mon,
                                                input logic leap);
      logic [DAY_W-1:0] len;
      if (mon == MONTH_FEB && leap) begin
         len = FEB_LEAP_DAYS;
      end else if (mon >= MONTH_JAN && mon <= MONTH_DEC) begin
         len = MONTH_LEN[mon];
      end else begin
         len = ODD_MONTH_DAYS;
      end
      return len;
   endfunction

endpackage

/* design/hour_offset_date_rollover_unit.sv */
// Top level of the hour offset date rollover unit: a four-stage pipeline that
// shifts a UTC timestamp by a signed hour offset. Depends on hodr_pkg.
//
// Use: an item enters on the req_ channel (valid/ready) as seconds, minutes,
// hours, day, month and year in UTC. The rsp_ channel (valid/ready) returns
// one item per input with the local time: the hour moved by the offset and
// the date rolled one day forward or back when midnight is crossed, using
// Gregorian month lengths. Seconds and minutes pass through unchanged.
// The offset is written through csr_wr_en/csr_wr_data; values outside
// -12..14 are dropped. Write it only while no items are in flight.
// Four register stages, each a single pass: hour add and year residue,
// divide by 25 estimate, leap test and month lookup, final date update.
// Throughput: one item per cycle while the receiver keeps taking results.
// Reset clears all stage valid bits and returns the offset to -3.
// When the receiver stalls, the output item holds and the stages behind it
// keep filling any empty slots; req_ready drops only once all four are full.
module hour_offset_date_rollover_unit import hodr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SEC_W-1:0]    req_seconds,
   input  logic [MIN_W-1:0]    req_minutes,
   input  logic [HOUR_W-1:0]   req_hours,
   input  logic [DAY_W-1:0]    req_day,
   input  logic [MONTH_W-1:0]  req_month,
   input  logic [YEAR_W-1:0]   req_year,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SEC_W-1:0]    rsp_seconds,
   output logic [MIN_W-1:0]    rsp_minutes,
   output logic [HOUR_W-1:0]   rsp_hours,
   output logic [DAY_W-1:0]    rsp_day,
   output logic [MONTH_W-1:0]  rsp_month,
   output logic [YEAR_W-1:0]   rsp_year,
   input  logic                csr_wr_en,
   input  logic [OFS_W-1:0]    csr_wr_data
);

   localparam int NH_W  = 7;   // hours plus offset spans -12..45
   localparam int SUM_W = 10;  // folded year residue sum stays below 661
   localparam int Q_W   = 5;   // estimate of sum / 25 stays below 27

   // Offset register.
   logic signed [OFS_W-1:0] hour_offset_ff;

   // Stage enables; a stage loads when it is empty or its item moves on.
   logic en1, en2, en3, en4;

   // Stage 1: hour sum and year residue terms.
   logic                      s1_valid_ff;
   logic [SEC_W-1:0]          s1_sec_ff;
   logic [MIN_W-1:0]          s1_min_ff;
   logic [HOUR_W-1:0]         s1_hr_ff;
   logic [DAY_W-1:0]          s1_day_ff;
   logic [MONTH_W-1:0]        s1_mon_ff;
   logic [YEAR_W-1:0]         s1_yr_ff;
   logic signed [NH_W-1:0]    s1_nh_ff;
   logic                      s1_zero_ff;
   logic [SUM_W-1:0]          s1_sum_ff;
   logic                      s1_y4z_ff;
   logic                      s1_y16z_ff;
   logic signed [NH_W-1:0]    s1_nh_in;
   logic [SUM_W-1:0]          s1_sum_in;

   // Stage 2: quotient estimate by 25.
   logic                      s2_valid_ff;
   logic [SEC_W-1:0]          s2_sec_ff;
   logic [MIN_W-1:0]          s2_min_ff;
   logic [HOUR_W-1:0]         s2_hr_ff;
   logic [DAY_W-1:0]          s2_day_ff;
   logic [MONTH_W-1:0]        s2_mon_ff;
   logic [YEAR_W-1:0]         s2_yr_ff;
   logic signed [NH_W-1:0]    s2_nh_ff;
   logic                      s2_zero_ff;
   logic [SUM_W-1:0]          s2_sum_ff;
   logic                      s2_y4z_ff;
   logic                      s2_y16z_ff;
   logic [Q_W-1:0]            s2_q_ff;
   logic [Q_W-1:0]            s2_q_in;

   // Stage 3: leap year, month lengths and the local hour.
   logic                      s3_valid_ff;
   logic [SEC_W-1:0]          s3_sec_ff;
   logic [MIN_W-1:0]          s3_min_ff;
   logic [HOUR_W-1:0]         s3_hr_ff;
   logic [DAY_W-1:0]          s3_day_ff;
   logic [MONTH_W-1:0]        s3_mon_ff;
   logic [YEAR_W-1:0]         s3_yr_ff;
   logic                      s3_back_ff;
   logic                      s3_fwd_ff;
   logic [DAY_W-1:0]          s3_days_cur_ff;
   logic [DAY_W-1:0]          s3_days_prev_ff;
   logic [HOUR_W-1:0]         s3_hr_in;
   logic                      s3_back_in;
   logic                      s3_fwd_in;
   logic [DAY_W-1:0]          s3_days_cur_in;
   logic [DAY_W-1:0]          s3_days_prev_in;

   // Stage 4: output register.
   logic                      s4_valid_ff;
   logic [SEC_W-1:0]          s4_sec_ff;
   logic [MIN_W-1:0]          s4_min_ff;
   logic [HOUR_W-1:0]         s4_hr_ff;
   logic [DAY_W-1:0]          s4_day_ff;
   logic [MONTH_W-1:0]        s4_mon_ff;
   logic [YEAR_W-1:0]         s4_yr_ff;
   logic [DAY_W-1:0]          s4_day_in;
   logic [MONTH_W-1:0]        s4_mon_in;
   logic [YEAR_W-1:0]         s4_yr_in;

   assign en4 = !s4_valid_ff || rsp_ready;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ready = en1;

   // Offset register; out-of-range writes leave it unchanged.
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en && $signed(csr_wr_data) >= OFFSET_MIN
                   && $signed(csr_wr_data) <= OFFSET_MAX) begin
         hour_offset_ff <= $signed(csr_wr_data);
      end
   end

   // Stage 1 logic. The year is folded modulo 25 by weighting its nibbles
   // with 16^k mod 25 (1, 16, 6, 21); a year divides by 25 exactly when
   // this sum does.
   always_comb begin
      s1_nh_in = $signed({2'b00, req_hours})
               + $signed({{(NH_W-OFS_W){hour_offset_ff[OFS_W-1]}}, hour_offset_ff});
      s1_sum_in = SUM_W'(req_year[3:0])
                + {2'b00, req_year[7:4], 4'b0000}
                + SUM_W'(req_year[11:8]) * SUM_W'(6)
                + SUM_W'(req_year[15:12]) * SUM_W'(21);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
      if (en1) begin
         s1_sec_ff  <= req_seconds;
         s1_min_ff  <= req_minutes;
         s1_hr_ff   <= req_hours;
         s1_day_ff  <= req_day;
         s1_mon_ff  <= req_month;
         s1_yr_ff   <= req_year;
         s1_nh_ff   <= s1_nh_in;
         s1_zero_ff <= (hour_offset_ff == '0);
         s1_sum_ff  <= s1_sum_in;
         s1_y4z_ff  <= (req_year[1:0] == 2'b00);
         s1_y16z_ff <= (req_year[3:0] == 4'b0000);
      end
   end

   // Stage 2: floor(sum / 25) as (sum * 41) >> 10, exact for sum below 661.
   logic [SUM_W+5:0] s2_prod;
   always_comb begin
      s2_prod = (SUM_W+6)'(s1_sum_ff) * (SUM_W+6)'(41);
      s2_q_in = s2_prod[SUM_W+4:SUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en2) begin
         s2_sec_ff  <= s1_sec_ff;
         s2_min_ff  <= s1_min_ff;
         s2_hr_ff   <= s1_hr_ff;
         s2_day_ff  <= s1_day_ff;
         s2_mon_ff  <= s1_mon_ff;
         s2_yr_ff   <= s1_yr_ff;
         s2_nh_ff   <= s1_nh_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_sum_ff  <= s1_sum_ff;
         s2_y4z_ff  <= s1_y4z_ff;
         s2_y16z_ff <= s1_y16z_ff;
         s2_q_ff    <= s2_q_in;
      end
   end

   // Stage 3. Given a multiple of 4, the year is a century exactly when it
   // divides by 25, and a multiple of 400 when it also divides by 16.
   logic                s3_div25;
   logic                s3_leap;
   logic                s3_neg;
   logic                s3_ge24;
   logic [MONTH_W-1:0]  s3_prev_mon;
   always_comb begin
      s3_div25 = (s2_sum_ff == SUM_W'(s2_q_ff) * SUM_W'(25));
      s3_leap  = s2_y4z_ff && (!s3_div25 || s2_y16z_ff);
      s3_neg   = s2_nh_ff[NH_W-1];
      s3_ge24  = !s3_neg && (s2_nh_ff >= $signed(NH_W'(24)));
      s3_prev_mon = (s2_mon_ff > MONTH_JAN) ? s2_mon_ff - 1'b1 : MONTH_DEC;
      s3_days_cur_in  = days_of(s2_mon_ff, s3_leap);
      s3_days_prev_in = days_of(s3_prev_mon, s3_leap);
      s3_back_in = !s2_zero_ff && s3_neg;
      s3_fwd_in  = !s2_zero_ff && s3_ge24;
      if (s2_zero_ff) begin
         s3_hr_in = s2_hr_ff;
      end else if (s3_neg) begin
         s3_hr_in = HOUR_W'(s2_nh_ff + $signed(NH_W'(24)));
      end else if (s3_ge24) begin
         s3_hr_in = HOUR_W'(s2_nh_ff - $signed(NH_W'(24)));
      end else begin
         s3_hr_in = HOUR_W'(s2_nh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en3) begin
         s3_sec_ff       <= s2_sec_ff;
         s3_min_ff       <= s2_min_ff;
         s3_hr_ff        <= s3_hr_in;
         s3_day_ff       <= s2_day_ff;
         s3_mon_ff       <= s2_mon_ff;
         s3_yr_ff        <= s2_yr_ff;
         s3_back_ff      <= s3_back_in;
         s3_fwd_ff       <= s3_fwd_in;
         s3_days_cur_ff  <= s3_days_cur_in;
         s3_days_prev_ff <= s3_days_prev_in;
      end
   end

   // Stage 4: step the date one day back or forward.
   always_comb begin
      s4_day_in = s3_day_ff;
      s4_mon_in = s3_mon_ff;
      s4_yr_in  = s3_yr_ff;
      if (s3_back_ff) begin
         if (s3_day_ff > DAY_W'(1)) begin
            s4_day_in = s3_day_ff - 1'b1;
         end else begin
            s4_day_in = s3_days_prev_ff;
            if (s3_mon_ff > MONTH_JAN) begin
               s4_mon_in = s3_mon_ff - 1'b1;
            end else begin
               s4_mon_in = MONTH_DEC;
               s4_yr_in  = s3_yr_ff - 1'b1;
            end
         end
      end else if (s3_fwd_ff) begin
         if (s3_day_ff < s3_days_cur_ff) begin
            s4_day_in = s3_day_ff + 1'b1;
         end else begin
            s4_day_in = DAY_W'(1);
            if (s3_mon_ff < MONTH_DEC) begin
               s4_mon_in = s3_mon_ff + 1'b1;
            end else begin
               s4_mon_in = MONTH_JAN;
               s4_yr_in  = s3_yr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (en4) begin
         s4_sec_ff <= s3_sec_ff;
         s4_min_ff <= s3_min_ff;
         s4_hr_ff  <= s3_hr_ff;
         s4_day_ff <= s4_day_in;
         s4_mon_ff <= s4_mon_in;
         s4_yr_ff  <= s4_yr_in;
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_seconds = s4_sec_ff;
   assign rsp_minutes = s4_min_ff;
   assign rsp_hours   = s4_hr_ff;
   assign rsp_day     = s4_day_ff;
   assign rsp_month   = s4_mon_ff;
   assign rsp_year    = s4_yr_ff;

endmodule

/* design/hodr_checker.sv */
// Port-level checker for the hour offset date rollover unit and its bind.
// Depends on hodr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hodr_checker import hodr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SEC_W-1:0]    rsp_seconds,
   input logic [MIN_W-1:0]    rsp_minutes,
   input logic [HOUR_W-1:0]   rsp_hours,
   input logic [DAY_W-1:0]    rsp_day,
   input logic [MONTH_W-1:0]  rsp_month,
   input logic [YEAR_W-1:0]   rsp_year
);

   property p_stall_holds;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_seconds, rsp_minutes, rsp_hours,
                                                        rsp_day, rsp_month, rsp_year});
   endproperty

   // The output is empty in the cycle after reset.
   `ASSERT_CLK(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result item stays put.
   `ASSERT_CLK_RST(a_stall_holds, clock, reset, p_stall_holds, "stalled result changed")

   // A receiver that takes items never back-pressures the sender.
   `ASSERT_CLK_RST(a_ready_follows, clock, reset, rsp_ready |-> req_ready, "input stalled")

   // An empty output stage always leaves room for a new item.
   `ASSERT_CLK_RST(a_empty_ready, clock, reset, !rsp_valid |-> req_ready, "blocked while empty")

endmodule

bind hour_offset_date_rollover_unit hodr_checker u_hodr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_seconds (rsp_seconds),
   .rsp_minutes (rsp_minutes),
   .rsp_hours   (rsp_hours),
   .rsp_day     (rsp_day),
   .rsp_month   (rsp_month),
   .rsp_year    (rsp_year)
);

/* tb/sv/hodr_local_time_checker.sv */
// Checker for the hour offset date rollover unit: tracks the offset register,
// predicts the local time of every accepted item and compares it on the rsp_ side.
// Depends on hodr_pkg for the field widths and the offset limits.
`timescale 1ns / 1ps

module hodr_local_time_checker import hodr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [SEC_W-1:0]    req_seconds,
   input  logic [MIN_W-1:0]    req_minutes,
   input  logic [HOUR_W-1:0]   req_hours,
   input  logic [DAY_W-1:0]    req_day,
   input  logic [MONTH_W-1:0]  req_month,
   input  logic [YEAR_W-1:0]   req_year,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [SEC_W-1:0]    rsp_seconds,
   input  logic [MIN_W-1:0]    rsp_minutes,
   input  logic [HOUR_W-1:0]   rsp_hours,
   input  logic [DAY_W-1:0]    rsp_day,
   input  logic [MONTH_W-1:0]  rsp_month,
   input  logic [YEAR_W-1:0]   rsp_year,
   input  logic                csr_wr_en,
   input  logic [OFS_W-1:0]    csr_wr_data,
   output int                  error_count,
   output int                  awaiting_count
);

   typedef struct packed {
      logic [SEC_W-1:0]   seconds;
      logic [MIN_W-1:0]   minutes;
      logic [HOUR_W-1:0]  hours;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } stamp_type;

   stamp_type               local_time_q [$];
   logic signed [OFS_W-1:0] zone_offset;

   function automatic bit year_has_feb29(int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   // Months outside January..December are taken to be 30 days long.
   function automatic int unsigned month_days(int unsigned mo, int unsigned yr);
      case (mo)
         2:                     return year_has_feb29(yr) ? 29 : 28;
         4, 6, 9, 11:           return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default:               return 30;
      endcase
   endfunction

   function automatic stamp_type to_local_time(stamp_type utc, logic signed [OFS_W-1:0] ofs);
      stamp_type   loc;
      int          hr_sum;
      int unsigned dy, mo, yr;
      loc    = utc;
      dy     = utc.day;
      mo     = utc.month;
      yr     = utc.year;
      hr_sum = int'(utc.hours) + int'(ofs);
      // A zero offset leaves the whole stamp alone, even an hour of 24 or more.
      if (ofs != 0) begin
         if (hr_sum < 0) begin
            hr_sum += 24;
            if (dy > 1) begin
               dy--;
            end else begin
               if (mo > 1) begin
                  mo--;
               end else begin
                  mo = 12;
                  yr = (yr - 1) & 16'hFFFF;
               end
               dy = month_days(mo, yr);
            end
         end else if (hr_sum >= 24) begin
            hr_sum -= 24;
            if (dy < month_days(mo, yr)) begin
               dy++;
            end else begin
               dy = 1;
               if (mo < 12) begin
                  mo++;
               end else begin
                  mo = 1;
                  yr = (yr + 1) & 16'hFFFF;
               end
            end
         end
         loc.hours = hr_sum[HOUR_W-1:0];
         loc.day   = dy[DAY_W-1:0];
         loc.month = mo[MONTH_W-1:0];
         loc.year  = yr[YEAR_W-1:0];
      end
      return loc;
   endfunction

   task automatic report_fault(string msg);
      $display("%0t ns local time check: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) begin
         report_fault($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      stamp_type got;
      stamp_type want;
      if (reset) begin
         local_time_q.delete();
         zone_offset = OFFSET_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_seconds, rsp_minutes, rsp_hours, rsp_day, rsp_month, rsp_year};
            if (local_time_q.size() == 0) begin
               report_fault($sformatf("unexpected item %0d-%0d-%0d %0d:%0d:%0d",
                  got.year, got.month, got.day, got.hours, got.minutes, got.seconds));
            end else begin
               want = local_time_q.pop_front();
               compare_field("seconds", got.seconds, want.seconds);
               compare_field("minutes", got.minutes, want.minutes);
               compare_field("hours", got.hours, want.hours);
               compare_field("day", got.day, want.day);
               compare_field("month", got.month, want.month);
               compare_field("year", got.year, want.year);
            end
         end
         if (req_valid && req_ready) begin
            local_time_q.push_back(to_local_time('{req_seconds, req_minutes, req_hours,
               req_day, req_month, req_year}, zone_offset));
         end
         if (csr_wr_en && $signed(csr_wr_data) >= OFFSET_MIN
               && $signed(csr_wr_data) <= OFFSET_MAX) begin
            zone_offset = csr_wr_data;
         end
      end
      awaiting_count <= local_time_q.size();
   end

endmodule

/* tb/sv/tb_hour_offset_date_rollover_unit.sv */
// Top of the testbench for the hour offset date rollover unit: clock, reset,
// stimulus, offset writes and the verdict. Depends on hodr_pkg, the unit and
// hodr_local_time_checker, which does all the prediction and comparing.
`timescale 1ns / 1ps

module tb_hour_offset_date_rollover_unit;
   import hodr_pkg::*;

   // This bound lies far above the length of the run, even under the heaviest
   // stalls, so it only trips when the unit stops moving items.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ROUND_ITEMS  = 56;
   localparam int ROUND_COUNT  = 8;
   localparam int SETTLE_WAIT  = 8;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [SEC_W-1:0]    req_seconds;
   logic [MIN_W-1:0]    req_minutes;
   logic [HOUR_W-1:0]   req_hours;
   logic [DAY_W-1:0]    req_day;
   logic [MONTH_W-1:0]  req_month;
   logic [YEAR_W-1:0]   req_year;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [SEC_W-1:0]    rsp_seconds;
   logic [MIN_W-1:0]    rsp_minutes;
   logic [HOUR_W-1:0]   rsp_hours;
   logic [DAY_W-1:0]    rsp_day;
   logic [MONTH_W-1:0]  rsp_month;
   logic [YEAR_W-1:0]   rsp_year;
   logic                csr_wr_en;
   logic [OFS_W-1:0]    csr_wr_data;

   int                  error_count;
   int                  awaiting_count;
   int                  cycle_count = 0;

   // Chance, in percent, that the sender stays idle and that the receiver
   // holds off in a given cycle.
   int                  idle_pct  = 0;
   int                  stall_pct = 0;

   // The offset the unit should hold now. It only steers the random hours
   // toward midnight crossings; the checker keeps its own copy.
   logic signed [OFS_W-1:0] zone_shift;

   hour_offset_date_rollover_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_seconds (req_seconds),
      .req_minutes (req_minutes),
      .req_hours   (req_hours),
      .req_day     (req_day),
      .req_month   (req_month),
      .req_year    (req_year),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_seconds (rsp_seconds),
      .rsp_minutes (rsp_minutes),
      .rsp_hours   (rsp_hours),
      .rsp_day     (rsp_day),
      .rsp_month   (rsp_month),
      .rsp_year    (rsp_year),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hodr_local_time_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_seconds    (req_seconds),
      .req_minutes    (req_minutes),
      .req_hours      (req_hours),
      .req_day        (req_day),
      .req_month      (req_month),
      .req_year       (req_year),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_seconds    (rsp_seconds),
      .rsp_minutes    (rsp_minutes),
      .rsp_hours      (rsp_hours),
      .rsp_day        (rsp_day),
      .rsp_month      (rsp_month),
      .rsp_year       (rsp_year),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .error_count    (error_count),
      .awaiting_count (awaiting_count)
   );

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Every input moves on the falling edge, so the unit and the checker both
   // see settled values at the rising edge.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_hour_offset_date_rollover_unit: errors");
         $finish;
      end
   end

   // Presents one item, holds it until the unit takes it and then, in the
   // idle phases, leaves the channel empty for a random run of cycles. Valid
   // only drops when a pause follows, so back-to-back items keep it high.
   task automatic send_stamp(input int unsigned sec, input int unsigned mins,
                             input int unsigned hr, input int unsigned dy,
                             input int unsigned mo, input int unsigned yr);
      req_seconds = sec[SEC_W-1:0];
      req_minutes = mins[MIN_W-1:0];
      req_hours   = hr[HOUR_W-1:0];
      req_day     = dy[DAY_W-1:0];
      req_month   = mo[MONTH_W-1:0];
      req_year    = yr[YEAR_W-1:0];
      req_valid   = 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
         end
      end
   endtask

   // Waits until every item in flight has come back, then lets the channel settle.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (awaiting_count != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // Offset writes go in only with the pipeline empty. Out-of-range patterns
   // are written too; the unit must keep its previous offset for those.
   task automatic write_offset(input logic signed [OFS_W-1:0] ofs);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = ofs;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      if (ofs >= OFFSET_MIN && ofs <= OFFSET_MAX) begin
         zone_shift = ofs;
      end
   endtask

   // One random item. Most are plausible dates, often with hours picked to cross
   // midnight and days near month ends or starts; the rest are raw noise over every
   // bit of every field, odd months and hours above 23 included.
   task automatic send_random_stamp();
      int unsigned yr;
      int unsigned mo;
      int unsigned dy;
      int unsigned hr;
      int          shift;
      shift = int'(zone_shift);
      if ($urandom_range(99) < 20) begin
         send_stamp($urandom_range(63), $urandom_range(63), $urandom_range(31),
                    $urandom_range(31), $urandom_range(15), $urandom_range(65535));
      end else begin
         case ($urandom_range(3))
            0:       yr = $urandom_range(65535);
            1:       yr = 1600 + 4 * $urandom_range(150);
            2:       yr = 100 * $urandom_range(655);
            default: yr = $urandom_range(1) ? 65535 : 0;
         endcase
         mo = $urandom_range(12, 1);
         case ($urandom_range(3))
            0:       dy = 1;
            1:       dy = $urandom_range(31, 28);
            default: dy = $urandom_range(31, 1);
         endcase
         if (shift != 0 && $urandom_range(1)) begin
            if (shift > 0) begin
               hr = $urandom_range(23, 24 - shift);
            end else begin
               hr = $urandom_range(-shift - 1, 0);
            end
         end else begin
            hr = $urandom_range(23);
         end
         send_stamp($urandom_range(59), $urandom_range(59), hr, dy, mo, yr);
      end
   endtask

   initial begin
      logic signed [OFS_W-1:0] round_offset;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_seconds = '0;
      req_minutes = '0;
      req_hours   = '0;
      req_day     = '0;
      req_month   = '0;
      req_year    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      zone_shift  = OFFSET_RESET;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed part, first at the reset offset of minus three hours.
      // New Year's Day of year 0 steps back into December of year 65535.
      send_stamp(0, 0, 0, 1, 1, 0);
      // Back from March 1 into February of a leap year and of a century year.
      send_stamp(59, 59, 2, 1, 3, 2000);
      send_stamp(0, 0, 1, 1, 3, 1900);
      // Day 0 of month 0 steps back like January.
      send_stamp(0, 0, 0, 0, 0, 2023);
      // Every field at its top value: hour 31 still moves forward past 23.
      send_stamp(63, 63, 31, 31, 15, 65535);
      // Back from a month above 12 only decrements the month.
      send_stamp(30, 30, 2, 1, 13, 2024);
      send_stamp(0, 0, 12, 15, 6, 2024);

      // Largest forward shift: year wrap, February ends, odd months as 30 days.
      write_offset(5'sd14);
      send_stamp(0, 0, 23, 31, 12, 65535);
      send_stamp(0, 0, 10, 28, 2, 2001);
      send_stamp(0, 0, 10, 28, 2, 2004);
      send_stamp(0, 0, 10, 29, 2, 2000);
      send_stamp(0, 0, 10, 30, 0, 100);
      send_stamp(0, 0, 10, 30, 14, 7);
      send_stamp(0, 0, 9, 30, 4, 2020);

      // Out-of-range writes, one just above the range and the lowest pattern, are dropped.
      write_offset(5'sd15);
      send_stamp(0, 0, 10, 31, 1, 1999);
      write_offset(-5'sd16);
      send_stamp(0, 0, 20, 0, 5, 2010);

      // Zero offset passes everything through, even hour 31.
      write_offset(5'sd0);
      send_stamp(63, 63, 31, 31, 15, 65535);
      send_stamp(0, 0, 0, 0, 0, 0);

      // Largest backward shift around century February rules.
      write_offset(-5'sd12);
      send_stamp(0, 0, 11, 1, 1, 2100);
      send_stamp(0, 0, 0, 1, 3, 2100);
      send_stamp(0, 0, 5, 1, 3, 2400);
      send_stamp(0, 0, 12, 1, 1, 0);
      write_offset(-5'sd13);
      send_stamp(0, 0, 3, 10, 8, 2030);

      // Random rounds. Each starts from an empty pipeline with an offset write,
      // out of range in some rounds, and cycles through the idle mixes: none,
      // sender pausing, receiver stalling, and both lightly.
      for (int round = 0; round < ROUND_COUNT; round++) begin
         case (round)
            0:       round_offset = 5'sd14;
            1:       round_offset = -5'sd12;
            4:       round_offset = 5'sd1;
            5:       round_offset = -5'sd1;
            3, 7:    round_offset = OFS_W'($urandom_range(31));
            default: round_offset = OFS_W'(int'($urandom_range(26)) - 12);
         endcase
         write_offset(round_offset);
         case (round % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 75;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 75;
            end
            default: begin
               idle_pct  = 13;
               stall_pct = 13;
            end
         endcase
         repeat (ROUND_ITEMS) send_random_stamp();
      end

      // Let the last items drain through before the verdict.
      wait_drained();
      if (error_count == 0) begin
         $display("tb_hour_offset_date_rollover_unit: clean");
      end else begin
         $display("tb_hour_offset_date_rollover_unit: errors");
      end
      $finish;
   end

endmodule

/* hour_offset_date_rollover_unit.f */
+incdir+design
design/hodr_pkg.sv
design/hour_offset_date_rollover_unit.sv
design/hodr_checker.sv
tb/sv/hodr_local_time_checker.sv
tb/sv/tb_hour_offset_date_rollover_unit.sv
